// ===== src/ttps_pkg.sv =====
// Package for the transposition table probe/store block.
// Field widths, bound kind and function codes, controller state and
// command/status structs. No dependencies.
package ttps_pkg;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 16;
  localparam int BOUND_W = 2;

  localparam logic FUNC_PROBE = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  localparam logic [BOUND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] KIND_ALPHA = 2'd1;
  localparam logic [BOUND_W-1:0] KIND_BETA  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic probe;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } status_t;

endpackage

// ===== src/ttps_req_if.sv =====
// Request channel interface: valid/ready plus one request word.
// Depends on ttps_pkg for field widths.
interface ttps_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [ttps_pkg::KEY_W-1:0]           key;
  logic [ttps_pkg::DEPTH_W-1:0]         depth;
  logic signed [ttps_pkg::SCORE_W-1:0]  score;
  logic [ttps_pkg::BOUND_W-1:0]         bound_kind;
  logic signed [ttps_pkg::SCORE_W-1:0]  alpha;
  logic signed [ttps_pkg::SCORE_W-1:0]  beta;

  modport source (output valid, func, key, depth, score, bound_kind, alpha, beta,
                  input ready);
  modport sink   (input valid, func, key, depth, score, bound_kind, alpha, beta,
                  output ready);
endinterface

// ===== src/ttps_rsp_if.sv =====
// Response channel interface: valid/ready plus one response word.
// Depends on ttps_pkg for field widths.
interface ttps_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic signed [ttps_pkg::SCORE_W-1:0]  score_out;

  modport source (output valid, hit, score_out, input ready);
  modport sink   (input valid, hit, score_out, output ready);
endinterface

// ===== src/ttps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ttps_ctrl.sv =====
// Controller FSM: clear pass after reset, request accept, probe lookup.
// Depends on ttps_pkg (state_t, cmd_t, status_t, function codes).
module ttps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  ttps_pkg::status_t status,
  output ttps_pkg::cmd_t    cmd
);

  ttps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ttps_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ttps_pkg::ST_IDLE;
        end
      end
      ttps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == ttps_pkg::FUNC_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.probe  = 1'b1;
            state_next = ttps_pkg::ST_LOOK;
          end
        end
      end
      ttps_pkg::ST_LOOK: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ttps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ttps_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/ttps_dp.sv =====
// Datapath: table RAM, clear counter, probe compare and response register.
// Depends on ttps_pkg and ttps_ram.
module ttps_dp #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ttps_pkg::cmd_t                      cmd,
  output ttps_pkg::status_t                   status,
  input  logic [ttps_pkg::KEY_W-1:0]          key,
  input  logic [ttps_pkg::DEPTH_W-1:0]        depth,
  input  logic signed [ttps_pkg::SCORE_W-1:0] score,
  input  logic [ttps_pkg::BOUND_W-1:0]        bound_kind,
  input  logic signed [ttps_pkg::SCORE_W-1:0] alpha,
  input  logic signed [ttps_pkg::SCORE_W-1:0] beta,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                rsp_hit,
  output logic signed [ttps_pkg::SCORE_W-1:0] rsp_score
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int TAG_W  = ttps_pkg::KEY_W - IDX_W;
  localparam int WORD_W = 1 + TAG_W + ttps_pkg::DEPTH_W + ttps_pkg::SCORE_W
                          + ttps_pkg::BOUND_W;

  // entry word: {valid, tag, depth, score, bound}
  logic [IDX_W-1:0]                  clr_idx;
  logic                              we;
  logic [IDX_W-1:0]                  waddr;
  logic [WORD_W-1:0]                 wdata;
  logic [WORD_W-1:0]                 rdata;

  logic [TAG_W-1:0]                  probe_tag;
  logic [ttps_pkg::DEPTH_W-1:0]      probe_depth;
  logic signed [ttps_pkg::SCORE_W-1:0] probe_alpha;
  logic signed [ttps_pkg::SCORE_W-1:0] probe_beta;

  logic                              e_valid;
  logic [TAG_W-1:0]                  e_tag;
  logic [ttps_pkg::DEPTH_W-1:0]      e_depth;
  logic signed [ttps_pkg::SCORE_W-1:0] e_score;
  logic [ttps_pkg::BOUND_W-1:0]      e_bound;
  logic                              match;
  logic                              hit_c;
  logic signed [ttps_pkg::SCORE_W-1:0] score_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign status.clear_done = (clr_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign status.out_free   = !rsp_valid || rsp_ready;

  assign we    = cmd.clear || cmd.store;
  assign waddr = cmd.clear ? clr_idx : key[IDX_W-1:0];
  assign wdata = cmd.clear ? '0
                           : {1'b1, key[ttps_pkg::KEY_W-1:IDX_W], depth, score, bound_kind};

  ttps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.probe),
    .raddr (key[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      probe_tag   <= key[ttps_pkg::KEY_W-1:IDX_W];
      probe_depth <= depth;
      probe_alpha <= alpha;
      probe_beta  <= beta;
    end
  end

  assign {e_valid, e_tag, e_depth, e_score, e_bound} = rdata;

  // an unwritten entry (valid clear) stands for depth -1: always a miss
  assign match = e_valid && (e_tag == probe_tag) && (e_depth >= probe_depth);

  always_comb begin
    hit_c   = 1'b0;
    score_c = '0;
    if (match) begin
      case (e_bound)
        ttps_pkg::KIND_EXACT: begin
          hit_c   = 1'b1;
          score_c = e_score;
        end
        ttps_pkg::KIND_ALPHA: begin
          if (e_score <= probe_alpha) begin
            hit_c   = 1'b1;
            score_c = probe_alpha;
          end
        end
        ttps_pkg::KIND_BETA: begin
          if (e_score >= probe_beta) begin
            hit_c   = 1'b1;
            score_c = probe_beta;
          end
        end
        default: begin
          hit_c   = 1'b0;
          score_c = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_hit   <= hit_c;
      rsp_score <= score_c;
    end
  end

endmodule

// ===== src/transposition_table_probe_store_core.sv =====
// Top level of the direct-mapped transposition table.
// Depends on ttps_pkg, ttps_req_if, ttps_rsp_if, ttps_ctrl, ttps_dp.

// Direct-mapped transposition table with TABLE_ENTRIES entries (a power of
// two); the low key bits pick the entry. After reset the block runs a
// clearing pass, one entry per cycle, with req.ready low. A store word is
// written in the cycle it is accepted and gives no response; the next word
// can follow in the next cycle. A probe word goes through the registered
// read of the table RAM and then the key, depth and bound compare that
// loads the response register. A probe waits in its compare step only while
// an earlier response is still held on rsp.
module transposition_table_probe_store_core #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  ttps_req_if.sink    req,
  ttps_rsp_if.source  rsp
);

  ttps_pkg::cmd_t    cmd;
  ttps_pkg::status_t status;

  ttps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_func  (req.func),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttps_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .key        (req.key),
    .depth      (req.depth),
    .score      (req.score),
    .bound_kind (req.bound_kind),
    .alpha      (req.alpha),
    .beta       (req.beta),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_hit    (rsp.hit),
    .rsp_score  (rsp.score_out)
  );

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.store, cmd.probe, cmd.load_out}))
    else $error("more than one datapath command at once");

  a_probe_blocks: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.func == ttps_pkg::FUNC_PROBE) |=> !req.ready)
    else $error("new word accepted during probe lookup");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp.valid)
    else $error("loaded response not presented");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp.valid || rsp.ready))
    else $error("response overwritten while held");
`endif

endmodule
